/* rtl/core/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared widths, angle constants and the stage word of the vector pair angle
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

  // input coordinate and result widths
  localparam int COORD_BITS    = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // number of cordic iterations actually built
  localparam int NSTAGE = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int IDX_W  = 5;

  // differences are pre-scaled for very wide coordinates
  localparam int PRE_SHIFT = (COORD_BITS > 29) ? (COORD_BITS - 29) : 0;
  localparam int DW        = COORD_BITS + 1 - PRE_SHIFT;
  localparam int MW        = 2 * DW;
  localparam int PW        = MW + 1;
  localparam int CW        = PW + 2;

  // turn constants, 2^32 is one full turn
  localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

  // output rounding
  localparam int          RND_SHIFT = 32 - ANGLE_BITS;
  localparam logic [32:0] RND_ADD   = (33'd1 << RND_SHIFT) >> 1;

  // atan(2^-i) as a fraction of a turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // word carried through the cordic iterations
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic        [31:0]   z;
    logic                 hold;
  } cordic_t;

endpackage

`default_nettype wire

/* rtl/core/vpa_cordic_stage.sv */
// ----------------------------------------------------------------------------
// vpa_cordic_stage
// One registered vectoring cordic iteration; rotates toward the x axis and
// accumulates the angle, or passes a held word through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_cordic_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic [vpa_pkg::IDX_W-1:0] stage_idx,
  input  wire logic                      in_valid,
  input  wire vpa_pkg::cordic_t          in_data,
  output      logic                      out_valid,
  output      vpa_pkg::cordic_t          out_data
);

  logic signed [vpa_pkg::CW-1:0] x_in;
  logic signed [vpa_pkg::CW-1:0] y_in;
  logic signed [vpa_pkg::CW-1:0] dx;
  logic signed [vpa_pkg::CW-1:0] dy;
  logic        [31:0]            atan_k;
  vpa_pkg::cordic_t              data_nxt;
  vpa_pkg::cordic_t              data_r;
  logic                          valid_r;

  // one micro-rotation, direction set by the sign of y
  always_comb begin
    x_in     = in_data.x;
    y_in     = in_data.y;
    dx       = x_in >>> stage_idx;
    dy       = y_in >>> stage_idx;
    atan_k   = vpa_pkg::ATAN_TURNS[stage_idx];
    data_nxt = in_data;
    if (!in_data.hold) begin
      if (y_in[vpa_pkg::CW-1]) begin
        data_nxt.x = x_in - dy;
        data_nxt.y = y_in + dx;
        data_nxt.z = in_data.z - atan_k;
      end else begin
        data_nxt.x = x_in + dy;
        data_nxt.y = y_in - dx;
        data_nxt.z = in_data.z + atan_k;
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
    if (load && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/core/vector_pair_angle.sv */
// ----------------------------------------------------------------------------
// vector_pair_angle
// Signed angle from the tip vector to the point vector around a shared origin.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one word of three points:
//   point, tip and origin. The block forms v1 = point - origin and
//   v2 = tip - origin, their dot product and determinant, and a vectoring
//   cordic gives atan2(det, dot). The result word (out_valid / out_ready)
//   carries out_angle_turns, an unsigned fraction of a turn in [0, 1).
//   Both products zero gives 0; axis cases are exact.
//   Registers in order: the differences, the multiplies, the sums, the
//   quadrant fold, one per cordic iteration, and the rounded output.
//   Throughput: one word per cycle; every stage is its own register with a
//   valid bit, so a new word enters each cycle while the pipeline flows.
//   Reset clears all valid bits; the pipeline comes up empty.
//   When the receiver stalls, words close up behind the output register
//   and in_ready drops only once every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_pair_angle (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output      logic                                    in_ready,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_point_x,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_point_y,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_tip_x,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_tip_y,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_origin_x,
  input  wire logic signed [vpa_pkg::COORD_BITS-1:0]   in_origin_y,
  output      logic                                    out_valid,
  input  wire logic                                    out_ready,
  output      logic        [vpa_pkg::ANGLE_BITS-1:0]   out_angle_turns
);

  localparam int NST = vpa_pkg::NSTAGE;

  // difference stage
  logic                                v1_r;
  logic signed [vpa_pkg::COORD_BITS:0] d1x_full, d1y_full, d2x_full, d2y_full;
  logic signed [vpa_pkg::DW-1:0]       v1x_r, v1y_r, v2x_r, v2y_r;
  // multiply stage
  logic                                v2_r;
  logic signed [vpa_pkg::MW-1:0]       p_xx_r, p_yy_r, p_xy_r, p_yx_r;
  // sum stage
  logic                                v3_r;
  logic signed [vpa_pkg::PW-1:0]       dot_r, det_r;
  // quadrant fold stage
  logic                                v4_r;
  vpa_pkg::cordic_t                    s4_nxt, s4_r;
  // cordic chain and output
  logic             [NST:0]            chain_v;
  vpa_pkg::cordic_t                    chain_d [NST+1];
  logic             [NST:0]            ld_chain;
  logic                                ld1, ld2, ld3, ld4, ld_out;
  logic                                out_valid_r;
  logic        [vpa_pkg::ANGLE_BITS-1:0] angle_nxt, angle_r;
  logic        [32:0]                  rnd_sum;

  // per-stage load enables: a stage loads when empty or when it drains
  assign ld_out         = !out_valid_r || out_ready;
  assign ld_chain[NST]  = ld_out;
  genvar gi;
  for (gi = 0; gi < NST; gi++) begin : g_ld
    assign ld_chain[gi] = !chain_v[gi+1] || ld_chain[gi+1];
  end
  assign ld4      = !v4_r || ld_chain[0];
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  // vector differences, floor-scaled for wide coordinates
  always_comb begin
    d1x_full = (vpa_pkg::COORD_BITS+1)'(in_point_x) - (vpa_pkg::COORD_BITS+1)'(in_origin_x);
    d1y_full = (vpa_pkg::COORD_BITS+1)'(in_point_y) - (vpa_pkg::COORD_BITS+1)'(in_origin_y);
    d2x_full = (vpa_pkg::COORD_BITS+1)'(in_tip_x) - (vpa_pkg::COORD_BITS+1)'(in_origin_x);
    d2y_full = (vpa_pkg::COORD_BITS+1)'(in_tip_y) - (vpa_pkg::COORD_BITS+1)'(in_origin_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_valid;
    end
    if (ld1 && in_valid) begin
      v1x_r <= vpa_pkg::DW'(d1x_full >>> vpa_pkg::PRE_SHIFT);
      v1y_r <= vpa_pkg::DW'(d1y_full >>> vpa_pkg::PRE_SHIFT);
      v2x_r <= vpa_pkg::DW'(d2x_full >>> vpa_pkg::PRE_SHIFT);
      v2y_r <= vpa_pkg::DW'(d2y_full >>> vpa_pkg::PRE_SHIFT);
    end
  end

  // four products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
    if (ld2 && v1_r) begin
      p_xx_r <= vpa_pkg::MW'(v2x_r) * vpa_pkg::MW'(v1x_r);
      p_yy_r <= vpa_pkg::MW'(v2y_r) * vpa_pkg::MW'(v1y_r);
      p_xy_r <= vpa_pkg::MW'(v2x_r) * vpa_pkg::MW'(v1y_r);
      p_yx_r <= vpa_pkg::MW'(v2y_r) * vpa_pkg::MW'(v1x_r);
    end
  end

  // dot product and determinant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
    if (ld3 && v2_r) begin
      dot_r <= vpa_pkg::PW'(p_xx_r) + vpa_pkg::PW'(p_yy_r);
      det_r <= vpa_pkg::PW'(p_xy_r) - vpa_pkg::PW'(p_yx_r);
    end
  end

  // axis cases settle the angle; a negative dot product turns half a turn
  always_comb begin
    s4_nxt.x    = vpa_pkg::CW'(dot_r);
    s4_nxt.y    = vpa_pkg::CW'(det_r);
    s4_nxt.z    = '0;
    s4_nxt.hold = 1'b0;
    if (det_r == '0) begin
      s4_nxt.hold = 1'b1;
      s4_nxt.z    = dot_r[vpa_pkg::PW-1] ? vpa_pkg::TURN_HALF : '0;
    end else if (dot_r == '0) begin
      s4_nxt.hold = 1'b1;
      s4_nxt.z    = det_r[vpa_pkg::PW-1] ? vpa_pkg::TURN_3QUARTER : vpa_pkg::TURN_QUARTER;
    end else if (dot_r[vpa_pkg::PW-1]) begin
      s4_nxt.x = -vpa_pkg::CW'(dot_r);
      s4_nxt.y = -vpa_pkg::CW'(det_r);
      s4_nxt.z = vpa_pkg::TURN_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ld4) begin
      v4_r <= v3_r;
    end
    if (ld4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  // cordic iterations
  assign chain_v[0] = v4_r;
  assign chain_d[0] = s4_r;
  for (gi = 0; gi < NST; gi++) begin : g_cordic
    vpa_cordic_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (ld_chain[gi]),
      .stage_idx (vpa_pkg::IDX_W'(gi)),
      .in_valid  (chain_v[gi]),
      .in_data   (chain_d[gi]),
      .out_valid (chain_v[gi+1]),
      .out_data  (chain_d[gi+1])
    );
  end

  // round to nearest at the output width, wrapping at one turn
  always_comb begin
    rnd_sum   = {1'b0, chain_d[NST].z} + vpa_pkg::RND_ADD;
    angle_nxt = rnd_sum[vpa_pkg::RND_SHIFT +: vpa_pkg::ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= chain_v[NST];
    end
    if (ld_out && chain_v[NST]) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_turns = angle_r;

  // input only backs up when every stage is full and the output is stalled
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && v4_r && (&chain_v[NST:1])))
    else $error("input stalled while the pipeline still has a free stage");

  // axis cases are exactly the words that bypass the cordic
  a_hold_matches_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ld4) |=> (s4_r.hold == ($past(dot_r) == '0 || $past(det_r) == '0)))
    else $error("hold flag does not match the axis cases");

  // after the fold the cordic starts in the right half plane
  a_fold_right_half: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !s4_r.hold) |-> !s4_r.x[vpa_pkg::CW-1])
    else $error("cordic started with a negative x");

endmodule

`default_nettype wire

/* bench/vpa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vpa_checker
// Watches both channels of vector_pair_angle, predicts the angle of every
// accepted word and compares it with the words that come out, in order.
// ----------------------------------------------------------------------------

module vpa_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_point_x,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_point_y,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_tip_x,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_tip_y,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_origin_x,
  input  logic signed [vpa_pkg::COORD_BITS-1:0]  in_origin_y,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic        [vpa_pkg::ANGLE_BITS-1:0]  out_angle_turns,
  output int                                     mismatches,
  output int                                     angles_outstanding
);

  // arctangent of 2^-i in 2^32 parts of a turn
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };
  localparam longint PRODUCT_CAP = longint'(1) <<< 40;
  localparam int     ITERATIONS  =
    (vpa_pkg::CORDIC_STAGES > 32) ? 32 : vpa_pkg::CORDIC_STAGES;

  logic [vpa_pkg::ANGLE_BITS-1:0] angles_due [$];

  initial begin
    mismatches = 0;
    angles_outstanding = 0;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // signed angle from tip vector to point vector, as a fraction of a turn
  function automatic logic [vpa_pkg::ANGLE_BITS-1:0] predict_angle(
    input longint px, input longint py, input longint tx, input longint ty,
    input longint ox, input longint oy
  );
    longint      v1x, v1y, v2x, v2y, dot, det, cx, cy, dx, dy;
    logic [31:0] z;
    logic [63:0] r;
    v1x = (px - ox) >>> vpa_pkg::PRE_SHIFT;
    v1y = (py - oy) >>> vpa_pkg::PRE_SHIFT;
    v2x = (tx - ox) >>> vpa_pkg::PRE_SHIFT;
    v2y = (ty - oy) >>> vpa_pkg::PRE_SHIFT;
    dot = v2x * v1x + v2y * v1y;
    det = v2x * v1y - v2y * v1x;
    if (det == 0) begin
      z = (dot < 0) ? vpa_pkg::TURN_HALF : 32'd0;
    end else if (dot == 0) begin
      z = (det > 0) ? vpa_pkg::TURN_QUARTER : vpa_pkg::TURN_3QUARTER;
    end else begin
      // scale both products down together until they fit
      while (magnitude(dot) >= PRODUCT_CAP || magnitude(det) >= PRODUCT_CAP) begin
        dot = dot >>> 1;
        det = det >>> 1;
      end
      cx = dot;
      cy = det;
      z  = '0;
      // left half plane is folded over by half a turn
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z  = vpa_pkg::TURN_HALF;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
        dx = cx >>> i;
        dy = cy >>> i;
        if (cy < 0) begin
          cx = cx - dy;
          cy = cy + dx;
          z  = z - ARCTAN_STEP[i];
        end else begin
          cx = cx + dy;
          cy = cy - dx;
          z  = z + ARCTAN_STEP[i];
        end
      end
    end
    // round half up to the output width, wrapping at a full turn
    r = {32'd0, z};
    if (vpa_pkg::ANGLE_BITS < 32) r = r + (64'd1 << (31 - vpa_pkg::ANGLE_BITS));
    r = r >> (32 - vpa_pkg::ANGLE_BITS);
    return r[vpa_pkg::ANGLE_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // result words are checked before the input word of the same edge is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected word, angle_turns", out_angle_turns, -1);
        end else begin
          if (out_angle_turns !== angles_due[0])
            report_mismatch("angle_turns", out_angle_turns, angles_due[0]);
          void'(angles_due.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        angles_due.push_back(predict_angle(
          longint'(in_point_x), longint'(in_point_y), longint'(in_tip_x),
          longint'(in_tip_y), longint'(in_origin_x), longint'(in_origin_y)));
      end
      angles_outstanding <= angles_due.size();
    end
  end

endmodule

/* bench/vector_pair_angle_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_pair_angle_tb
// Drives point, tip and origin words into vector_pair_angle with random
// gaps and output stalls; vpa_checker predicts and compares each angle.
// ----------------------------------------------------------------------------

module vector_pair_angle_tb;

  localparam int RANDOM_WORDS = 900;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 40;
  localparam int STALL_CYCLES = 300;
  localparam int CB           = vpa_pkg::COORD_BITS;

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_ready;
  logic signed [CB-1:0]                   in_point_x, in_point_y;
  logic signed [CB-1:0]                   in_tip_x, in_tip_y;
  logic signed [CB-1:0]                   in_origin_x, in_origin_y;
  logic                                   out_valid;
  logic                                   out_ready;
  logic        [vpa_pkg::ANGLE_BITS-1:0]  out_angle_turns;

  int  mismatches;
  int  angles_outstanding;
  int  cycle_count = 0;
  bit  sender_calm = 1'b0;
  bit  stall_request = 1'b0;
  bit  stall_done = 1'b0;

  always #6 clk = ~clk;

  vector_pair_angle u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_tip_x        (in_tip_x),
    .in_tip_y        (in_tip_y),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_angle_turns (out_angle_turns)
  );

  vpa_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_tip_x           (in_tip_x),
    .in_tip_y           (in_tip_y),
    .in_origin_x        (in_origin_x),
    .in_origin_y        (in_origin_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_angle_turns    (out_angle_turns),
    .mismatches         (mismatches),
    .angles_outstanding (angles_outstanding)
  );

  // mostly short idle stretches, a few long ones
  function automatic int idle_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate drawn from the field extremes or anywhere
  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // offer one word and hold it until accepted, then maybe idle
  task automatic send_points(input int px, input int py, input int tx, input int ty,
                             input int ox, input int oy);
    int gap;
    in_valid    <= 1'b1;
    in_point_x  <= px[CB-1:0];
    in_point_y  <= py[CB-1:0];
    in_tip_x    <= tx[CB-1:0];
    in_tip_y    <= ty[CB-1:0];
    in_origin_x <= ox[CB-1:0];
    in_origin_y <= oy[CB-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = idle_len(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every predicted angle to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (angles_outstanding != 0) @(posedge clk);
  endtask

  // one random word, shaped to reach the axis and wrap cases often
  task automatic send_random_points();
    int ox, oy, dx, dy, k;
    ox = $urandom_range(0, 2000) - 1000;
    oy = $urandom_range(0, 2000) - 1000;
    dx = $urandom_range(0, 2000) - 1000;
    dy = $urandom_range(0, 2000) - 1000;
    k  = $urandom_range(0, 6) - 3;
    case ($urandom_range(0, 9)) inside
      [0:3]: begin
        send_points($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
      end
      [4:5]: begin
        // tiny coordinates, zero products are frequent
        send_points($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                    $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                    $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
      end
      6: send_points(ox + k * dx, oy + k * dy, ox + dx, oy + dy, ox, oy);
      7: send_points(ox - k * dy, oy + k * dx, ox + dx, oy + dy, ox, oy);
      8: send_points(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord());
      default: begin
        // point just off the tip direction, angles near zero and a full turn
        send_points(ox + 8 * dx + $urandom_range(0, 2) - 1,
                    oy + 8 * dy + $urandom_range(0, 2) - 1,
                    ox + 8 * dx, oy + 8 * dy, ox, oy);
      end
    endcase
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random ready, one long hold-off when asked
  initial begin
    int lo;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (stall_request && !stall_done) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
        else repeat ($urandom_range(1, 20)) @(posedge clk);
        lo = idle_len(1'b0);
        if (lo > 0) begin
          out_ready <= 1'b0;
          repeat (lo) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_point_x  <= '0;
    in_point_y  <= '0;
    in_tip_x    <= '0;
    in_tip_y    <= '0;
    in_origin_x <= '0;
    in_origin_y <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both products zero, then the exact axis cases
    send_points(0, 0, 0, 0, 0, 0);
    send_points(5, -7, 5, -7, 5, -7);
    send_points(9, 4, 1, 2, 9, 4);
    send_points(4, 0, 2, 0, 0, 0);
    send_points(-4, 0, 2, 0, 0, 0);
    send_points(0, 3, 2, 0, 0, 0);
    send_points(0, -3, 2, 0, 0, 0);
    // negative dot product off the axes
    send_points(-5, 2, 3, 1, 0, 0);
    send_points(-5, -2, 3, 1, 0, 0);
    // field extremes
    send_points(32767, 32767, -32768, -32768, -32768, 32767);
    send_points(-32768, -32768, 32767, 32767, 32767, -32768);
    send_points(32767, -32768, -32768, 32767, 0, 0);
    send_points(-32768, 32767, 32767, -32768, -1, -1);
    // slightly negative angle that rounds up to a full turn
    send_points(32767, -1, 32767, 0, -32768, 0);
    send_points(32767, 1, 32767, 0, -32768, 0);
    // eight directions around a shifted origin
    for (int a = 0; a < 8; a++) begin
      send_points(100 + ((a % 4 == 0) ? 0 : ((a < 4) ? 1000 : -1000)),
                  -50 + ((a % 4 == 2) ? 0 : ((a < 2 || a > 6) ? 1000 : -1000)),
                  1100, -50, 100, -50);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (n == 100) stall_request = 1'b1;
      if (n == 450) wait_drained();
      send_random_points();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
